// ----- hdl/pmsfp_pkg.sv -----
// pmsfp_pkg: types and constants for the sensor frame parser
// used by pmsfp_frame, pmsfp_drain and pm_sensor_frame_parser; no dependencies
package pmsfp_pkg;

	localparam int FRAME_BYTES   = 32;
	localparam int READING_COUNT = 13;
	localparam int SUM_END       = 30;
	localparam int DATA_START    = 4;

	localparam int POS_W   = 5;
	localparam int SUM_W   = 13;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 4;
	localparam int VALUE_W = 16;

	localparam logic [7:0] HDR_FIRST  = 8'h42;
	localparam logic [7:0] HDR_SECOND = 8'h4D;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_HEADER   = 2'd1,
		ST_CHECKSUM = 2'd2,
		ST_SHORT    = 2'd3
	} status_t;

	typedef logic [READING_COUNT-1:0][VALUE_W-1:0] reading_arr_t;

	typedef struct packed {
		logic    hit;
		status_t status;
	} frame_evt_t;

endpackage

// ----- hdl/pm_sensor_frame_parser.sv -----
// pm_sensor_frame_parser: top level of the particulate sensor frame parser
// instantiates pmsfp_frame and pmsfp_drain; depends on pmsfp_pkg
//
//   channel   handshake                   word
//   byte      byte_valid / byte_ready     is_gap, data_byte
//   result    result_valid / result_ready status, field_index, field_value, last
//
// one byte accepted per cycle; results appear in the cycle after a closing byte
// a good frame gives 13 words, one per cycle while result_ready stays high
// a byte that closes a frame waits until the result register is empty or
// hands out its last word in that same cycle; other bytes are accepted at any time
// arst_n clears position, sum and the result count and sets the header flag
module pm_sensor_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic        is_gap,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [3:0]  field_index,
	output logic [15:0] field_value,
	output logic        last
);

	pmsfp_pkg::frame_evt_t   evt;
	pmsfp_pkg::reading_arr_t readings;
	logic                    can_load;
	logic                    take;

	assign byte_ready = !evt.hit || can_load;
	assign take       = byte_valid && byte_ready;

	pmsfp_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.is_gap    (is_gap),
		.data_byte (data_byte),
		.evt       (evt),
		.readings  (readings)
	);

	pmsfp_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take && evt.hit),
		.load_status  (evt.status),
		.readings     (readings),
		.result_ready (result_ready),
		.can_load     (can_load),
		.result_valid (result_valid),
		.status       (status),
		.field_index  (field_index),
		.field_value  (field_value),
		.last         (last)
	);

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != 2'(pmsfp_pkg::ST_OK))
			|-> (last && field_index == '0 && field_value == '0))
		else $error("error word not a single zeroed word");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last && status == 2'(pmsfp_pkg::ST_OK))
			|-> (field_index == 4'(pmsfp_pkg::READING_COUNT - 1)))
		else $error("last reading at wrong index");

	a_hit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(take && evt.hit) |=> (result_valid && field_index == '0))
		else $error("closed frame gave no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(take && evt.hit && result_valid) |-> (last && result_ready))
		else $error("frame closed over pending results");

endmodule

// ----- hdl/pmsfp_frame.sv -----
// pmsfp_frame: byte position, running sum, header check and reading store
// judges a frame on its final byte or on a gap; depends on pmsfp_pkg
module pmsfp_frame (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic                     is_gap,
	input  logic [7:0]               data_byte,
	output pmsfp_pkg::frame_evt_t    evt,
	output pmsfp_pkg::reading_arr_t  readings
);

	logic [pmsfp_pkg::POS_W-1:0]   pos_q;
	logic [pmsfp_pkg::SUM_W-1:0]   sum_q;
	logic                          header_good_q;
	logic [7:0]                    checksum_high_q;
	logic [7:0]                    pending_high_q;
	pmsfp_pkg::reading_arr_t       store_q;

	logic                          pos_zero;
	logic                          pos_end;
	logic                          in_sum;
	logic                          in_data;
	logic [pmsfp_pkg::POS_W-1:0]   pos_off;
	logic [pmsfp_pkg::IDX_W-1:0]   slot;
	logic [15:0]                   expect_sum;

	assign pos_zero   = (pos_q == '0);
	assign pos_end    = (pos_q == pmsfp_pkg::POS_W'(pmsfp_pkg::FRAME_BYTES - 1));
	assign in_sum     = (pos_q < pmsfp_pkg::POS_W'(pmsfp_pkg::SUM_END));
	assign in_data    = in_sum && (pos_q >= pmsfp_pkg::POS_W'(pmsfp_pkg::DATA_START));
	assign pos_off    = pos_q - pmsfp_pkg::POS_W'(pmsfp_pkg::DATA_START);
	assign slot       = pmsfp_pkg::IDX_W'(pos_off >> 1);
	assign expect_sum = {checksum_high_q, data_byte};

	always_comb begin
		evt.hit    = is_gap ? !pos_zero : pos_end;
		evt.status = pmsfp_pkg::ST_OK;
		if (is_gap) begin
			evt.status = pmsfp_pkg::ST_SHORT;
		end else if (!header_good_q) begin
			evt.status = pmsfp_pkg::ST_HEADER;
		end else if (16'(sum_q) != expect_sum) begin
			evt.status = pmsfp_pkg::ST_CHECKSUM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q           <= '0;
			sum_q           <= '0;
			header_good_q   <= 1'b1;
			checksum_high_q <= '0;
			pending_high_q  <= '0;
		end else if (take) begin
			if (is_gap || pos_end) begin
				if (!pos_zero) begin
					pos_q         <= '0;
					sum_q         <= '0;
					header_good_q <= 1'b1;
				end
			end else begin
				if (pos_zero) begin
					header_good_q <= (data_byte == pmsfp_pkg::HDR_FIRST);
				end else if (pos_q == pmsfp_pkg::POS_W'(1)) begin
					header_good_q <= header_good_q && (data_byte == pmsfp_pkg::HDR_SECOND);
				end
				if (in_sum) begin
					sum_q <= sum_q + pmsfp_pkg::SUM_W'(data_byte);
				end
				if (pos_q == pmsfp_pkg::POS_W'(pmsfp_pkg::SUM_END)) begin
					checksum_high_q <= data_byte;
				end else if (in_data && !pos_off[0]) begin
					pending_high_q <= data_byte;
				end
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// reading store, no reset
	always_ff @(posedge clk) begin
		if (take && !is_gap && in_data && pos_off[0]) begin
			store_q[slot] <= {pending_high_q, data_byte};
		end
	end

	assign readings = store_q;

endmodule

// ----- hdl/pmsfp_drain.sv -----
// pmsfp_drain: result register holding one error word or thirteen readings
// shifts results out one word per accept; depends on pmsfp_pkg
module pmsfp_drain (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  pmsfp_pkg::status_t                   load_status,
	input  pmsfp_pkg::reading_arr_t              readings,
	input  logic                                 result_ready,
	output logic                                 can_load,
	output logic                                 result_valid,
	output logic [1:0]                           status,
	output logic [pmsfp_pkg::IDX_W-1:0]          field_index,
	output logic [pmsfp_pkg::VALUE_W-1:0]        field_value,
	output logic                                 last
);

	logic [pmsfp_pkg::CNT_W-1:0] cnt_q;
	logic [pmsfp_pkg::IDX_W-1:0] idx_q;
	pmsfp_pkg::reading_arr_t     buf_q;
	pmsfp_pkg::status_t          status_q;
	logic                        pop;

	assign result_valid = (cnt_q != '0);
	assign pop          = result_valid && result_ready;
	assign last         = (cnt_q == pmsfp_pkg::CNT_W'(1));
	assign can_load     = (cnt_q == '0) || (last && result_ready);
	assign status       = status_q;
	assign field_index  = idx_q;
	assign field_value  = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			idx_q <= '0;
			if (load_status == pmsfp_pkg::ST_OK) begin
				cnt_q <= pmsfp_pkg::CNT_W'(pmsfp_pkg::READING_COUNT);
			end else begin
				cnt_q <= pmsfp_pkg::CNT_W'(1);
			end
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= load_status;
			if (load_status == pmsfp_pkg::ST_OK) begin
				buf_q <= readings;
			end else begin
				buf_q <= '0;
			end
		end else if (pop) begin
			buf_q <= {pmsfp_pkg::VALUE_W'(0), buf_q[pmsfp_pkg::READING_COUNT-1:1]};
		end
	end

endmodule
